// ===== src/csfs_pkg.sv =====
// Shared types and constants of the CAN standard frame serializer.
// No dependencies; every other file but csfs_bit_if imports this package.
package csfs_pkg;

  // Field widths
  localparam int unsigned ID_W   = 11;
  localparam int unsigned DLC_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 15;

  // Frame layout
  localparam int unsigned HDR_BITS  = 19;  // SOF, ID, RTR, IDE, r0, DLC
  localparam int unsigned TRL_BITS  = 13;  // CRC delim, ACK, ACK delim, EOF, intermission
  localparam int unsigned MAX_BYTES = 8;
  localparam int unsigned RUN_LIMIT = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned RUN_W     = 3;
  localparam int unsigned NB_W      = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

  localparam logic [CNT_W-1:0] CNT_HDR  = CNT_W'(HDR_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_BYTE = CNT_W'(BYTE_W - 1);
  localparam logic [CNT_W-1:0] CNT_CRC  = CNT_W'(CRC_W - 1);
  localparam logic [CNT_W-1:0] CNT_TRL  = CNT_W'(TRL_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_ACK  = CNT_W'(TRL_BITS - 2);

  // Request kinds
  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  // Bit source select
  localparam logic [1:0] SRC_SHIFT = 2'd0;
  localparam logic [1:0] SRC_CRC   = 2'd1;
  localparam logic [1:0] SRC_TRL   = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic       load_hdr;
    logic       load_byte;
    logic       step;
    logic       enter_crc;
    logic       enter_trl;
    logic       run_last;
    logic [1:0] src;
  } csfs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic phase_end;
  } csfs_sts_t;

endpackage

// ===== src/csfs_req_if.sv =====
// Request channel of the serializer: valid/ready and one frame item.
// Depends on csfs_pkg for field widths.
interface csfs_req_if
  import csfs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   frame_id;
  logic              remote_request;
  logic [DLC_W-1:0]  length_code;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, req_type, frame_id, remote_request, length_code,
                  data_byte, input ready);
  modport sink   (input valid, req_type, frame_id, remote_request, length_code,
                  data_byte, output ready);
endinterface

// ===== src/csfs_bit_if.sv =====
// Result channel of the serializer: valid/ready and one line bit.
// Depends on nothing beyond the language.
interface csfs_bit_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic is_stuff_bit;
  logic frame_end;
  logic run_last;

  modport source (output valid, bit_value, is_stuff_bit, frame_end, run_last,
                  input ready);
  modport sink   (input valid, bit_value, is_stuff_bit, frame_end, run_last,
                  output ready);
endinterface

// ===== src/can_standard_frame_serializer.sv =====
// CAN 2.0A frame serializer: one line bit per cycle unless stalled; registered output.
// An item is loaded when taken; its first bit is then stepped into the output register.
// One item at a time; a header emits 19..55 bits, a data byte 8..42, one bit per
// cycle while the sink is ready, after a load step for each item.
// The next item can be taken in the cycle after the previous item's last bit is stepped.
// Reset: asynchronous, active low; clears sequencer and stuffing state, ACK slot dominant.
module can_standard_frame_serializer
  import csfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  csfs_req_if.sink   req_i,
  csfs_bit_if.source out_o
);

  logic      ack_dom_q;
  csfs_cmd_t cmd;
  csfs_sts_t sts;

  // ACK slot configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_dom_q <= 1'b1;
    end else if (cfg_we_i) begin
      ack_dom_q <= cfg_wdata_i;
    end
  end

  csfs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_i.valid),
    .req_ready_o      (req_i.ready),
    .req_type_i       (req_i.req_type),
    .remote_request_i (req_i.remote_request),
    .length_code_i    (req_i.length_code),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  csfs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ack_dom_i        (ack_dom_q),
    .frame_id_i       (req_i.frame_id),
    .remote_request_i (req_i.remote_request),
    .length_code_i    (req_i.length_code),
    .data_byte_i      (req_i.data_byte),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_o            (out_o)
  );

`ifndef ASSERT_OFF
  // Last trailer bit closes the item and is never a stuff bit
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_end |-> out_o.run_last && !out_o.is_stuff_bit)
    else $error("frame_end without run_last");

  // No bit is stepped while a new request may be taken
  a_idle_nostep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !cmd.step)
    else $error("bit stepped while idle");

  // Loads happen only on an accepted request
  a_load_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_hdr || cmd.load_byte) |-> req_i.valid && req_i.ready)
    else $error("load without accepted request");

  // A stepped bit shows up at the output next cycle
  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> out_o.valid)
    else $error("stepped bit not presented");
`endif

endmodule

// ===== src/csfs_ctrl.sv =====
// Frame sequencer: walks header, data, CRC and trailer phases.
// Depends on csfs_pkg; drives the datapath through csfs_cmd_t.
module csfs_ctrl
  import csfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic             req_type_i,
  input  logic             remote_request_i,
  input  logic [DLC_W-1:0] length_code_i,
  input  csfs_sts_t        sts_i,
  output csfs_cmd_t        cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_CRC  = 3'd3;
  localparam logic [2:0] ST_TRL  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [NB_W-1:0] bytes_left_q, bytes_left_d;
  logic            frame_open_q, frame_open_d;
  logic [NB_W-1:0] nbytes;
  logic [NB_W-1:0] bytes_dec;

  // Data bytes the header asks for
  always_comb begin
    if (remote_request_i) begin
      nbytes = '0;
    end else if (length_code_i > DLC_W'(MAX_BYTES)) begin
      nbytes = NB_W'(MAX_BYTES);
    end else begin
      nbytes = NB_W'(length_code_i);
    end
  end

  assign bytes_dec   = bytes_left_q - NB_W'(1);
  assign req_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    bytes_left_d  = bytes_left_q;
    frame_open_d  = frame_open_q;
    cmd_o         = '0;
    cmd_o.src     = SRC_SHIFT;
    cmd_o.step    = (state_q != ST_IDLE) && sts_i.slot_free;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == REQ_HEADER) begin
            cmd_o.load_hdr = 1'b1;
            bytes_left_d   = nbytes;
            frame_open_d   = 1'b1;
            state_d        = ST_HDR;
          end else if (frame_open_q && (bytes_left_q != '0)) begin
            cmd_o.load_byte = 1'b1;
            state_d         = ST_DATA;
          end
        end
      end
      ST_HDR: begin
        if (cmd_o.step && sts_i.phase_end) begin
          if (bytes_left_q == '0) begin
            cmd_o.enter_crc = 1'b1;
            state_d         = ST_CRC;
          end else begin
            cmd_o.run_last = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (cmd_o.step && sts_i.phase_end) begin
          bytes_left_d = bytes_dec;
          if (bytes_dec == '0) begin
            cmd_o.enter_crc = 1'b1;
            state_d         = ST_CRC;
          end else begin
            cmd_o.run_last = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_CRC: begin
        cmd_o.src = SRC_CRC;
        if (cmd_o.step && sts_i.phase_end) begin
          cmd_o.enter_trl = 1'b1;
          state_d         = ST_TRL;
        end
      end
      ST_TRL: begin
        cmd_o.src = SRC_TRL;
        if (cmd_o.step && sts_i.phase_end) begin
          cmd_o.run_last = 1'b1;
          frame_open_d   = 1'b0;
          bytes_left_d   = '0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bytes_left_q <= '0;
      frame_open_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      bytes_left_q <= bytes_left_d;
      frame_open_q <= frame_open_d;
    end
  end

endmodule

// ===== src/csfs_dp.sv =====
// Serializer datapath: shift register, CRC-15, stuffing state, bit counter
// and the output register. Depends on csfs_pkg and csfs_bit_if.
module csfs_dp
  import csfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ack_dom_i,
  input  logic [ID_W-1:0]   frame_id_i,
  input  logic              remote_request_i,
  input  logic [DLC_W-1:0]  length_code_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  csfs_cmd_t         cmd_i,
  output csfs_sts_t         sts_o,
  csfs_bit_if.source        out_o
);

  logic [HDR_BITS-1:0] sh_q, sh_d;
  logic [CRC_W-1:0]    crc_q, crc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic                last_q, last_d;
  logic                pend_q, pend_d;
  logic                empty_q, empty_d;
  logic                ov_q, ov_d;
  logic                bit_q, bit_d;
  logic                stf_q, stf_d;
  logic                end_q, end_d;
  logic                rl_q, rl_d;
  logic                cur_bit;
  logic                stuff_now;
  logic                fb;

  // Bit of the current phase
  always_comb begin
    case (cmd_i.src)
      SRC_SHIFT: cur_bit = sh_q[HDR_BITS-1];
      SRC_CRC:   cur_bit = crc_q[CRC_W-1];
      SRC_TRL:   cur_bit = (cnt_q == CNT_ACK) ? ~ack_dom_i : 1'b1;
      default:   cur_bit = 1'b1;
    endcase
  end

  // Fifth equal bit in a stuffed region
  assign stuff_now = (cmd_i.src != SRC_TRL) && !pend_q && (cur_bit == last_q) &&
                     (run_q == RUN_W'(RUN_LIMIT - 1));
  assign fb        = cur_bit ^ crc_q[CRC_W-1];

  assign sts_o.slot_free = !ov_q || out_o.ready;
  assign sts_o.phase_end = pend_q ? empty_q : ((cnt_q == '0) && !stuff_now);

  always_comb begin
    sh_d    = sh_q;
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    last_d  = last_q;
    pend_d  = pend_q;
    empty_d = empty_q;
    ov_d    = ov_q && !out_o.ready;
    bit_d   = bit_q;
    stf_d   = stf_q;
    end_d   = end_q;
    rl_d    = rl_q;
    if (cmd_i.load_hdr) begin
      // Idle bus counts as recessive at frame start
      sh_d    = {1'b0, frame_id_i, remote_request_i, 2'b00, length_code_i};
      cnt_d   = CNT_HDR;
      crc_d   = '0;
      run_d   = RUN_W'(1);
      last_d  = 1'b1;
      pend_d  = 1'b0;
      empty_d = 1'b0;
    end else if (cmd_i.load_byte) begin
      sh_d  = {data_byte_i, (HDR_BITS - BYTE_W)'(0)};
      cnt_d = CNT_BYTE;
    end else if (cmd_i.step) begin
      ov_d = 1'b1;
      rl_d = cmd_i.run_last;
      if (pend_q) begin
        // Inserted complement bit
        bit_d   = ~last_q;
        stf_d   = 1'b1;
        end_d   = 1'b0;
        last_d  = ~last_q;
        run_d   = RUN_W'(1);
        pend_d  = 1'b0;
        empty_d = 1'b0;
      end else begin
        bit_d = cur_bit;
        stf_d = 1'b0;
        end_d = (cmd_i.src == SRC_TRL) && (cnt_q == '0);
        if (cmd_i.src == SRC_SHIFT) begin
          sh_d  = {sh_q[HDR_BITS-2:0], 1'b0};
          crc_d = {crc_q[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end else if (cmd_i.src == SRC_CRC) begin
          crc_d = {crc_q[CRC_W-2:0], 1'b0};
        end
        if (cur_bit == last_q) begin
          if (run_q != RUN_W'(RUN_LIMIT)) begin
            run_d = run_q + RUN_W'(1);
          end
        end else begin
          run_d  = RUN_W'(1);
          last_d = cur_bit;
        end
        if (stuff_now) begin
          pend_d  = 1'b1;
          empty_d = (cnt_q == '0);
        end
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      if (cmd_i.enter_crc) begin
        cnt_d = CNT_CRC;
      end else if (cmd_i.enter_trl) begin
        cnt_d = CNT_TRL;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      run_q   <= RUN_W'(1);
      last_q  <= 1'b1;
      pend_q  <= 1'b0;
      empty_q <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      run_q   <= run_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
      empty_q <= empty_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bit_q <= bit_d;
    stf_q <= stf_d;
    end_q <= end_d;
    rl_q  <= rl_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.bit_value    = bit_q;
  assign out_o.is_stuff_bit = stf_q;
  assign out_o.frame_end    = end_q;
  assign out_o.run_last     = rl_q;

endmodule
